>>> hdl/tlpp_pkg.sv
// shared types and constants for the tape line position pid block
package tlpp_pkg;

    // field widths fixed by the interface
    localparam int POS_W      = 3;
    localparam int ERR_W      = 4;
    localparam int DIFF_W     = 5;
    localparam int DIR_W      = 4;
    localparam int GAIN_W     = 16;
    localparam int CORR_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_MIDDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDEAL_POS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd6;

    // register reset values
    localparam int THRESH_LR_RESET = 40;
    localparam int THRESH_R_RESET  = 37;
    localparam logic [POS_W-1:0] IDEAL_POS_RESET = 3'd3;

    // line positions
    localparam logic [POS_W-1:0] POS_FAR_RIGHT = 3'd0;
    localparam logic [POS_W-1:0] POS_MED_RIGHT = 3'd1;
    localparam logic [POS_W-1:0] POS_SLT_RIGHT = 3'd2;
    localparam logic [POS_W-1:0] POS_CENTER    = 3'd3;
    localparam logic [POS_W-1:0] POS_SLT_LEFT  = 3'd4;
    localparam logic [POS_W-1:0] POS_MED_LEFT  = 3'd5;
    localparam logic [POS_W-1:0] POS_FAR_LEFT  = 3'd6;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_ON        = 4'd0;
    localparam logic [DIR_W-1:0] DIR_SLIGHT_R  = 4'd1;
    localparam logic [DIR_W-1:0] DIR_MED_R     = 4'd2;
    localparam logic [DIR_W-1:0] DIR_BIG_R     = 4'd3;
    localparam logic [DIR_W-1:0] DIR_SLIGHT_L  = 4'd4;
    localparam logic [DIR_W-1:0] DIR_MED_L     = 4'd5;
    localparam logic [DIR_W-1:0] DIR_BIG_L     = 4'd6;
    localparam logic [DIR_W-1:0] DIR_NO_MATCH  = 4'd7;
    localparam logic [DIR_W-1:0] DIR_LOST      = 4'd8;

    // sensor patterns, left middle right
    localparam logic [2:0] PAT_NONE   = 3'b000;
    localparam logic [2:0] PAT_R      = 3'b001;
    localparam logic [2:0] PAT_M      = 3'b010;
    localparam logic [2:0] PAT_MR     = 3'b011;
    localparam logic [2:0] PAT_L      = 3'b100;
    localparam logic [2:0] PAT_LM     = 3'b110;
    localparam logic [2:0] PAT_LMR    = 3'b111;

    // per-item fields that ride along with the products
    typedef struct packed {
        logic [POS_W-1:0]        position;
        logic signed [ERR_W-1:0] error;
        logic [DIR_W-1:0]        code;
    } item_info_t;

endpackage

>>> hdl/tlpp_classify.sv
// sensor lanes, pattern classification and per-item controller state
module tlpp_classify
    import tlpp_pkg::*;
#(
    parameter int SAMPLE_BITS   = 10,
    parameter int INTEGRAL_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [SAMPLE_BITS-1:0]          sample_left,
    input  logic [SAMPLE_BITS-1:0]          sample_middle,
    input  logic [SAMPLE_BITS-1:0]          sample_right,
    input  logic [SAMPLE_BITS-1:0]          thresh_left,
    input  logic [SAMPLE_BITS-1:0]          thresh_middle,
    input  logic [SAMPLE_BITS-1:0]          thresh_right,
    input  logic [POS_W-1:0]                ideal_pos,
    output item_info_t                      info,
    output logic signed [INTEGRAL_BITS-1:0] integral,
    output logic signed [DIFF_W-1:0]        diff
);

    logic [2:0]                      bits;
    logic [2:0]                      prev_bits_reg, prev_bits_next;
    logic [POS_W-1:0]                pos_reg, pos_next;
    logic [POS_W-1:0]                far_reg, far_next;
    logic signed [ERR_W-1:0]         err_reg, err_next;
    logic signed [ERR_W-1:0]         prev_err_reg;
    logic [DIR_W-1:0]                lost_reg, lost_next;
    logic [DIR_W-1:0]                code_reg, code_next;
    logic signed [INTEGRAL_BITS-1:0] integ_reg, integ_next;
    logic signed [DIFF_W-1:0]        diff_reg, diff_next;
    logic [POS_W-1:0]                pos_cand;
    logic                            set_pos;
    logic signed [INTEGRAL_BITS:0]   integ_ext;

    // one compare per sensor lane
    assign bits = {sample_left > thresh_left, sample_middle > thresh_middle,
                   sample_right > thresh_right};

    // pattern table and off-tape recovery
    always_comb begin
        pos_cand  = pos_reg;
        set_pos   = 1'b1;
        code_next = DIR_NO_MATCH;
        lost_next = lost_reg;
        far_next  = far_reg;
        unique case (bits)
            PAT_M, PAT_LMR: begin
                pos_cand = POS_CENTER;    code_next = DIR_ON;       lost_next = DIR_LOST;
            end
            PAT_LM: begin
                pos_cand = POS_SLT_RIGHT; code_next = DIR_SLIGHT_R; lost_next = DIR_LOST;
            end
            PAT_L: begin
                pos_cand = POS_MED_RIGHT; code_next = DIR_MED_R;    lost_next = DIR_LOST;
            end
            PAT_MR: begin
                pos_cand = POS_SLT_LEFT;  code_next = DIR_SLIGHT_L; lost_next = DIR_LOST;
            end
            PAT_R: begin
                pos_cand = POS_MED_LEFT;  code_next = DIR_MED_L;    lost_next = DIR_LOST;
            end
            PAT_NONE: begin
                priority if (prev_bits_reg[2]) begin
                    pos_cand  = POS_FAR_RIGHT;
                    code_next = DIR_BIG_R;
                    lost_next = DIR_BIG_R;
                    far_next  = POS_FAR_RIGHT;
                end else if (prev_bits_reg[0]) begin
                    pos_cand  = POS_FAR_LEFT;
                    code_next = DIR_BIG_L;
                    lost_next = DIR_BIG_L;
                    far_next  = POS_FAR_LEFT;
                end else begin
                    code_next = lost_reg;
                    if (far_reg == POS_FAR_RIGHT || far_reg == POS_FAR_LEFT) begin
                        pos_cand = far_reg;
                    end else begin
                        set_pos = 1'b0;
                    end
                end
            end
            default: begin
                set_pos = 1'b0;
            end
        endcase
    end

    // held position and error, error recomputed only when position is set
    always_comb begin
        prev_bits_next = bits;
        pos_next       = set_pos ? pos_cand : pos_reg;
        err_next       = set_pos ? ERR_W'(signed'({1'b0, ideal_pos}) - signed'({1'b0, pos_cand}))
                                 : err_reg;
    end

    // saturating integral and first difference
    always_comb begin
        integ_ext = {integ_reg[INTEGRAL_BITS-1], integ_reg}
                  + {{(INTEGRAL_BITS+1-ERR_W){err_next[ERR_W-1]}}, err_next};
        if (integ_ext[INTEGRAL_BITS] != integ_ext[INTEGRAL_BITS-1]) begin
            integ_next = integ_ext[INTEGRAL_BITS]
                       ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
                       : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
        end else begin
            integ_next = integ_ext[INTEGRAL_BITS-1:0];
        end
        diff_next = {err_next[ERR_W-1], err_next} - {prev_err_reg[ERR_W-1], prev_err_reg};
    end

    // state advances once per accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_bits_reg <= 3'b000;
            pos_reg       <= POS_CENTER;
            far_reg       <= POS_CENTER;
            err_reg       <= '0;
            prev_err_reg  <= '0;
            lost_reg      <= DIR_LOST;
            integ_reg     <= '0;
        end else if (accept) begin
            prev_bits_reg <= prev_bits_next;
            pos_reg       <= pos_next;
            far_reg       <= far_next;
            err_reg       <= err_next;
            prev_err_reg  <= err_next;
            lost_reg      <= lost_next;
            integ_reg     <= integ_next;
        end
    end

    // per-item payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            code_reg <= code_next;
            diff_reg <= diff_next;
        end
    end

    assign info.position = pos_reg;
    assign info.error    = err_reg;
    assign info.code     = code_reg;
    assign integral      = integ_reg;
    assign diff          = diff_reg;

endmodule

>>> hdl/tlpp_term_lane.sv
// one pid term lane: signed operand times a q8.8 gain, registered
module tlpp_term_lane
    import tlpp_pkg::*;
#(
    parameter int A_W = 4
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [A_W-1:0]        operand,
    input  logic signed [GAIN_W-1:0]     gain,
    output logic signed [A_W+GAIN_W-1:0] product
);

    logic signed [A_W+GAIN_W-1:0] prod_reg, prod_next;

    // full-precision signed product
    always_comb begin
        prod_next = (A_W+GAIN_W)'(operand) * (A_W+GAIN_W)'(gain);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;

endmodule

>>> hdl/tlpp_merge.sv
// merge stage: adds the three term products and saturates to 32 bits
module tlpp_merge
    import tlpp_pkg::*;
#(
    parameter int INTEGRAL_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  item_info_t                             info_in,
    input  logic signed [ERR_W+GAIN_W-1:0]         p_term,
    input  logic signed [INTEGRAL_BITS+GAIN_W-1:0] i_term,
    input  logic signed [DIFF_W+GAIN_W-1:0]        d_term,
    output item_info_t                             info_out,
    output logic signed [CORR_W-1:0]               correction
);

    localparam int P_W   = ERR_W + GAIN_W;
    localparam int I_W   = INTEGRAL_BITS + GAIN_W;
    localparam int D_W   = DIFF_W + GAIN_W;
    localparam int SUM_W = (I_W + 2 > CORR_W + 2) ? I_W + 2 : CORR_W + 2;
    localparam int TOP_W = SUM_W - CORR_W + 1;

    logic signed [SUM_W-1:0]  sum;
    logic [TOP_W-1:0]         top_bits;
    logic signed [CORR_W-1:0] corr_reg, corr_next;
    item_info_t               info_reg;

    // sign-extended sum of the lanes
    always_comb begin
        sum = {{(SUM_W-P_W){p_term[P_W-1]}}, p_term}
            + {{(SUM_W-I_W){i_term[I_W-1]}}, i_term}
            + {{(SUM_W-D_W){d_term[D_W-1]}}, d_term};
        top_bits = sum[SUM_W-1:CORR_W-1];
    end

    // clamp to the signed 32-bit range
    always_comb begin
        if ((&top_bits) || !(|top_bits)) begin
            corr_next = sum[CORR_W-1:0];
        end else if (sum[SUM_W-1]) begin
            corr_next = {1'b1, {(CORR_W-1){1'b0}}};
        end else begin
            corr_next = {1'b0, {(CORR_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            corr_reg <= corr_next;
            info_reg <= info_in;
        end
    end

    assign correction = corr_reg;
    assign info_out   = info_reg;

endmodule

>>> hdl/tape_line_position_pid.sv
// top level of the tape line position pid block
//
//  channel   direction  fields (low bit first)                       handshake
//  s_        in         sample_left, sample_middle, sample_right     s_tvalid / s_tready
//  m_        out        line_position, position_error,               m_tvalid / m_tready
//                       direction_code, correction
//  cfg_      in         cfg_index, cfg_data                          cfg_valid / cfg_ready
//
// one request per cycle unless the output register is full and not taken; each result
// passes through the registered classify/state, three multiplier lanes, and sum and saturate
// a synchronous active-low reset clears the pipeline valid bits, the controller state
// and the configuration registers to their defaults; no clearing pass
// the whole pipeline holds when the output register is full and not taken;
// configuration writes are always accepted
module tape_line_position_pid
    import tlpp_pkg::*;
#(
    parameter int SAMPLE_BITS   = 10,
    parameter int INTEGRAL_BITS = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // sample_left, sample_middle, sample_right, zero pad
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]           s_tdata,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // line_position, position_error, direction_code, correction, zero pad
    output logic [((POS_W+ERR_W+DIR_W+CORR_W+7)/8)*8-1:0] m_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    input  logic [CFG_IDX_W-1:0]                         cfg_index,
    input  logic [CFG_DATA_W-1:0]                        cfg_data,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready
);

    localparam int M_W   = ((POS_W+ERR_W+DIR_W+CORR_W+7)/8)*8;
    localparam int M_USE = POS_W + ERR_W + DIR_W + CORR_W;

    logic [SAMPLE_BITS-1:0]          thr_left_reg, thr_middle_reg, thr_right_reg;
    logic [POS_W-1:0]                ideal_reg;
    logic signed [GAIN_W-1:0]        gain_p_reg, gain_i_reg, gain_d_reg;
    logic                            v1_reg, v2_reg, v3_reg;
    logic                            adv;
    logic                            accept;
    item_info_t                      info1, info2_reg, info3;
    logic signed [INTEGRAL_BITS-1:0] integral;
    logic signed [DIFF_W-1:0]        diff;
    logic signed [ERR_W+GAIN_W-1:0]  p_term;
    logic signed [INTEGRAL_BITS+GAIN_W-1:0] i_term;
    logic signed [DIFF_W+GAIN_W-1:0] d_term;
    logic signed [CORR_W-1:0]        correction;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_left_reg   <= SAMPLE_BITS'(THRESH_LR_RESET);
            thr_middle_reg <= SAMPLE_BITS'(THRESH_LR_RESET);
            thr_right_reg  <= SAMPLE_BITS'(THRESH_R_RESET);
            ideal_reg      <= IDEAL_POS_RESET;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_THRESH_LEFT:   thr_left_reg   <= cfg_data[SAMPLE_BITS-1:0];
                CFG_THRESH_MIDDLE: thr_middle_reg <= cfg_data[SAMPLE_BITS-1:0];
                CFG_THRESH_RIGHT:  thr_right_reg  <= cfg_data[SAMPLE_BITS-1:0];
                CFG_IDEAL_POS:     ideal_reg      <= cfg_data[POS_W-1:0];
                CFG_GAIN_P:        gain_p_reg     <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:        gain_i_reg     <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:        gain_d_reg     <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline moves whenever the output register can take a new result
    assign adv      = !v3_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage one: sensor lanes and classification
    tlpp_classify #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_classify (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .sample_left   (s_tdata[SAMPLE_BITS-1:0]),
        .sample_middle (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .sample_right  (s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .thresh_left   (thr_left_reg),
        .thresh_middle (thr_middle_reg),
        .thresh_right  (thr_right_reg),
        .ideal_pos     (ideal_reg),
        .info          (info1),
        .integral      (integral),
        .diff          (diff)
    );

    // stage two: three term lanes
    tlpp_term_lane #(.A_W(ERR_W)) u_lane_p (
        .aclk    (aclk),
        .en      (adv),
        .operand (info1.error),
        .gain    (gain_p_reg),
        .product (p_term)
    );

    tlpp_term_lane #(.A_W(INTEGRAL_BITS)) u_lane_i (
        .aclk    (aclk),
        .en      (adv),
        .operand (integral),
        .gain    (gain_i_reg),
        .product (i_term)
    );

    tlpp_term_lane #(.A_W(DIFF_W)) u_lane_d (
        .aclk    (aclk),
        .en      (adv),
        .operand (diff),
        .gain    (gain_d_reg),
        .product (d_term)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            info2_reg <= info1;
        end
    end

    // stage three: merge into the output register
    tlpp_merge #(.INTEGRAL_BITS(INTEGRAL_BITS)) u_merge (
        .aclk       (aclk),
        .en         (adv),
        .info_in    (info2_reg),
        .p_term     (p_term),
        .i_term     (i_term),
        .d_term     (d_term),
        .info_out   (info3),
        .correction (correction)
    );

    // result packing
    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(M_W-M_USE){1'b0}}, correction, info3.code, info3.error,
                       info3.position};

endmodule
